[rtl/ata_pkg.sv]
// Shared constants, types and arithmetic helpers for the alarm time add/subtract block.
// No dependencies; every other file of the block imports this package.

package ata_pkg;

   localparam int FIELD_W = 8;
   localparam int DELTA_W = 22;
   localparam int QUO_W   = 17;
   localparam int STAGES  = 8;
   localparam int OCC_W   = $clog2(STAGES + 1);

   localparam logic OP_ADD = 1'b0;
   localparam logic OP_SUB = 1'b1;

   localparam logic [FIELD_W-1:0] DONT_CARE = 8'd255;
   localparam logic [FIELD_W-1:0] FEBRUARY  = 8'd2;
   localparam logic [FIELD_W-1:0] DECEMBER  = 8'd12;

   localparam logic [5:0] BASE_MIN_SEC = 6'd60;
   localparam logic [5:0] BASE_HOUR    = 6'd24;
   localparam logic [5:0] MONTHS       = 6'd12;
   localparam logic [8:0] MONTH_OFFSET = 9'd11;
   localparam logic [4:0] LEN_DEFAULT  = 5'd31;
   localparam logic [4:0] LEN_FEB_LEAP = 5'd29;

   // Reciprocals for exact quotients: ceil(2^shift / divisor).
   localparam logic [22:0] RECIP_SEC = 23'd4473925;
   localparam int          SHIFT_SEC = 28;
   localparam logic [17:0] RECIP_MIN = 18'd139811;
   localparam int          SHIFT_MIN = 23;
   localparam logic [11:0] RECIP_HR  = 12'd2731;
   localparam int          SHIFT_HR  = 16;
   localparam int          RECIP_SHIFT = 15;

   localparam logic [4:0] MONTH_DAYS [12] = '{
      5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
      5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
   };

   typedef struct packed {
      logic [FIELD_W-1:0] value;
      logic [QUO_W-1:0]   carry;
   } step_type;

   typedef struct packed {
      logic               sub;
      logic               leap;
      logic [FIELD_W-1:0] second;
      logic [FIELD_W-1:0] minute;
      logic [FIELD_W-1:0] hour;
      logic [FIELD_W-1:0] day;
      logic [FIELD_W-1:0] month;
      logic [DELTA_W-1:0] carry;
      logic [QUO_W-1:0]   quo;
      logic [5:0]         sec_m;
      logic [5:0]         min_m;
      logic [4:0]         hr_m;
      logic               go;
      logic [3:0]         mon_t;
      logic [4:0]         len;
      logic [3:0]         d0_q;
      logic [4:0]         d0_m;
   } pipe_type;

   function automatic logic [11:0] recip15(input logic [5:0] d);
      logic [11:0] m;
      unique case (d)
         MONTHS:       m = 12'd2731;
         BASE_HOUR:    m = 12'd1366;
         6'd28:        m = 12'd1171;
         6'd29:        m = 12'd1130;
         6'd30:        m = 12'd1093;
         6'd31:        m = 12'd1058;
         BASE_MIN_SEC: m = 12'd547;
         default:      m = 12'd547;
      endcase
      return m;
   endfunction

   // Remainder of a nine-bit value by one of the small divisors above.
   function automatic logic [5:0] mod_small(input logic [8:0] x, input logic [5:0] d);
      logic [20:0] prod;
      logic [5:0]  quo;
      logic [11:0] back;
      logic [8:0]  rem;
      prod = 21'(x) * 21'(recip15(d));
      quo  = prod[RECIP_SHIFT +: 6];
      back = 12'(quo) * 12'(d);
      rem  = x - back[8:0];
      return rem[5:0];
   endfunction

   function automatic logic [4:0] month_len(input logic [FIELD_W-1:0] m, input logic leap);
      logic [3:0] idx;
      logic [4:0] len;
      idx = m[3:0] - 4'd1;
      if (m == '0 || m > DECEMBER) begin
         len = LEN_DEFAULT;
      end else if (m == FEBRUARY && leap) begin
         len = LEN_FEB_LEAP;
      end else begin
         len = MONTH_DAYS[idx];
      end
      return len;
   endfunction

   // One carry or borrow step of a field; vm is the field modulo base, rc the
   // carry modulo base and quo the carry divided by base.
   function automatic step_type part_step(input logic sub, input logic [FIELD_W-1:0] v,
                                          input logic [5:0] vm, input logic [5:0] rc,
                                          input logic [QUO_W-1:0] quo,
                                          input logic [5:0] base);
      logic [6:0] sum;
      logic [8:0] wrap;
      step_type   res;
      res.carry = quo;
      if (sub) begin
         if ({2'b0, rc} > v) begin
            wrap      = {1'b0, v} + {3'b0, base} - {3'b0, rc};
            res.value = wrap[7:0];
            res.carry = quo + 17'd1;
         end else begin
            res.value = v - {2'b0, rc};
         end
      end else begin
         sum = {1'b0, vm} + {1'b0, rc};
         if (sum >= {1'b0, base}) begin
            sum = sum - {1'b0, base};
         end
         res.value = {1'b0, sum};
         if (res.value < v) begin
            res.carry = quo + 17'd1;
         end
      end
      return res;
   endfunction

endpackage

[rtl/ata_req_if.sv]
// Request channel of the alarm time add/subtract block: valid, ready and one alarm item.
// Depends on ata_pkg for the field widths.

interface ata_req_if;
   import ata_pkg::*;

   logic               valid;
   logic               ready;
   logic               op;
   logic [DELTA_W-1:0] delta_seconds;
   logic               leap_year;
   logic [FIELD_W-1:0] in_second;
   logic [FIELD_W-1:0] in_minute;
   logic [FIELD_W-1:0] in_hour;
   logic [FIELD_W-1:0] in_day;
   logic [FIELD_W-1:0] in_month;

   modport source (output valid, op, delta_seconds, leap_year, in_second, in_minute,
                   in_hour, in_day, in_month, input ready);
   modport sink (input valid, op, delta_seconds, leap_year, in_second, in_minute,
                 in_hour, in_day, in_month, output ready);
endinterface

[rtl/ata_rsp_if.sv]
// Response channel of the alarm time add/subtract block: valid, ready and the adjusted alarm.
// Depends on ata_pkg for the field widths.

interface ata_rsp_if;
   import ata_pkg::*;

   logic               valid;
   logic               ready;
   logic [FIELD_W-1:0] out_second;
   logic [FIELD_W-1:0] out_minute;
   logic [FIELD_W-1:0] out_hour;
   logic [FIELD_W-1:0] out_day;
   logic [FIELD_W-1:0] out_month;

   modport source (output valid, out_second, out_minute, out_hour, out_day, out_month,
                   input ready);
   modport sink (input valid, out_second, out_minute, out_hour, out_day, out_month,
                 output ready);
endinterface

[rtl/alarm_time_add_subtract.sv]
// Alarm time add/subtract: eight-stage pipeline that shifts an alarm setting by a second count.
// Depends on ata_pkg, ata_req_if and ata_rsp_if.
// An accepted request transaction passes through the stage registers pipe_ff[0] to pipe_ff[7] to a valid response.
// Throughput is one transaction per cycle while responses are taken; each stage moves whenever it is empty or the
// stage after it moves, so bubbles close up while a response waits to be taken.
// Synchronous reset clears the stage valid bits; the payload registers are not reset.

module alarm_time_add_subtract (
   input logic       clock,
   input logic       reset,
   ata_req_if.sink   req_bus,
   ata_rsp_if.source rsp_bus
);
   import ata_pkg::*;

   pipe_type          pipe_ff [STAGES];
   pipe_type          pipe_in [STAGES];
   logic [STAGES-1:0] valid_ff;
   logic [STAGES-1:0] adv;

   logic [44:0]        a_prod;
   logic [5:0]         a_sec_m;
   logic [5:0]         a_min_m;
   logic [5:0]         a_hr_m;
   logic [21:0]        b_back;
   logic [21:0]        b_rem;
   step_type           b_step;
   logic [34:0]        c_prod;
   logic [5:0]         c_t;
   logic [5:0]         c_pm;
   logic [FIELD_W-1:0] c_prev;
   logic [16:0]        d_back;
   logic [16:0]        d_rem;
   step_type           d_step;
   logic [22:0]        e_prod;
   logic [FIELD_W-1:0] e_d0;
   logic [19:0]        e_dprod;
   logic [10:0]        f_back;
   logic [10:0]        f_rem;
   logic [FIELD_W-1:0] f_d0;
   logic [8:0]         f_dback;
   logic [FIELD_W-1:0] f_drem;
   step_type           f_step;
   logic [FIELD_W-1:0] g_d0;
   logic [5:0]         g_c;
   logic               g_ge;
   logic [5:0]         g_rc;
   logic               g_act;
   step_type           g_step;
   logic [5:0]         h_k;
   logic [5:0]         h_t;

   always_comb begin
      adv[STAGES-1] = !valid_ff[STAGES-1] || rsp_bus.ready;
      for (int k = STAGES - 2; k >= 0; k--) begin
         adv[k] = !valid_ff[k] || adv[k+1];
      end
   end

   assign req_bus.ready = adv[0];

   // Quotient of the delta by 60 and field remainders.
   always_comb begin
      a_prod  = 45'(req_bus.delta_seconds) * 45'(RECIP_SEC);
      a_sec_m = mod_small({1'b0, req_bus.in_second}, BASE_MIN_SEC);
      a_min_m = mod_small({1'b0, req_bus.in_minute}, BASE_MIN_SEC);
      a_hr_m  = mod_small({1'b0, req_bus.in_hour}, BASE_HOUR);
      pipe_in[0]        = '0;
      pipe_in[0].sub    = (req_bus.op == OP_SUB);
      pipe_in[0].leap   = req_bus.leap_year;
      pipe_in[0].second = req_bus.in_second;
      pipe_in[0].minute = req_bus.in_minute;
      pipe_in[0].hour   = req_bus.in_hour;
      pipe_in[0].day    = req_bus.in_day;
      pipe_in[0].month  = req_bus.in_month;
      pipe_in[0].carry  = req_bus.delta_seconds;
      pipe_in[0].quo    = a_prod[SHIFT_SEC +: QUO_W];
      pipe_in[0].sec_m  = a_sec_m;
      pipe_in[0].min_m  = a_min_m;
      pipe_in[0].hr_m   = a_hr_m[4:0];
      pipe_in[0].go     = 1'b1;
   end

   // Second.
   always_comb begin
      b_back = {5'b0, pipe_ff[0].quo} * 22'(BASE_MIN_SEC);
      b_rem  = pipe_ff[0].carry - b_back;
      b_step = part_step(pipe_ff[0].sub, pipe_ff[0].second, pipe_ff[0].sec_m, b_rem[5:0],
                         pipe_ff[0].quo, BASE_MIN_SEC);
      pipe_in[1]    = pipe_ff[0];
      pipe_in[1].go = (pipe_ff[0].carry != '0) && (pipe_ff[0].second != DONT_CARE);
      if (pipe_in[1].go) begin
         pipe_in[1].second = b_step.value;
         pipe_in[1].carry  = DELTA_W'(b_step.carry);
      end
   end

   // Quotient by 60 for the minute, and month preparation.
   always_comb begin
      c_prod = 35'(pipe_ff[1].carry[16:0]) * 35'(RECIP_MIN);
      c_prev = pipe_ff[1].month - 8'd1;
      c_t    = mod_small({1'b0, pipe_ff[1].month} + MONTH_OFFSET, MONTHS);
      c_pm   = mod_small({1'b0, c_prev} + MONTH_OFFSET, MONTHS) + 6'd1;
      pipe_in[2]       = pipe_ff[1];
      pipe_in[2].quo   = QUO_W'(c_prod[34:SHIFT_MIN]);
      pipe_in[2].mon_t = c_t[3:0];
      if (pipe_ff[1].month == DONT_CARE) begin
         pipe_in[2].len = LEN_DEFAULT;
      end else if (pipe_ff[1].sub) begin
         pipe_in[2].len = month_len({2'b0, c_pm}, pipe_ff[1].leap);
      end else begin
         pipe_in[2].len = month_len(pipe_ff[1].month, pipe_ff[1].leap);
      end
   end

   // Minute.
   always_comb begin
      d_back = pipe_ff[2].quo * 17'(BASE_MIN_SEC);
      d_rem  = pipe_ff[2].carry[16:0] - d_back;
      d_step = part_step(pipe_ff[2].sub, pipe_ff[2].minute, pipe_ff[2].min_m, d_rem[5:0],
                         pipe_ff[2].quo, BASE_MIN_SEC);
      pipe_in[3]    = pipe_ff[2];
      pipe_in[3].go = pipe_ff[2].go && (pipe_ff[2].carry != '0) &&
                      (pipe_ff[2].minute != DONT_CARE);
      if (pipe_in[3].go) begin
         pipe_in[3].minute = d_step.value;
         pipe_in[3].carry  = DELTA_W'(d_step.carry);
      end
   end

   // Quotient by 24 for the hour, and quotient of the day index by the month length.
   always_comb begin
      e_prod  = 23'(pipe_ff[3].carry[10:0]) * 23'(RECIP_HR);
      e_d0    = pipe_ff[3].day - 8'd1;
      e_dprod = 20'(e_d0) * 20'(recip15({1'b0, pipe_ff[3].len}));
      pipe_in[4]      = pipe_ff[3];
      pipe_in[4].quo  = QUO_W'(e_prod[22:SHIFT_HR]);
      pipe_in[4].d0_q = e_dprod[RECIP_SHIFT +: 4];
   end

   // Hour, and the day index modulo the month length.
   always_comb begin
      f_back  = 11'(pipe_ff[4].quo[6:0]) * 11'(BASE_HOUR);
      f_rem   = pipe_ff[4].carry[10:0] - f_back;
      f_step  = part_step(pipe_ff[4].sub, pipe_ff[4].hour, {1'b0, pipe_ff[4].hr_m},
                          f_rem[5:0], pipe_ff[4].quo, BASE_HOUR);
      f_d0    = pipe_ff[4].day - 8'd1;
      f_dback = 9'(pipe_ff[4].d0_q) * 9'(pipe_ff[4].len);
      f_drem  = f_d0 - f_dback[7:0];
      pipe_in[5]      = pipe_ff[4];
      pipe_in[5].d0_m = f_drem[4:0];
      pipe_in[5].go   = pipe_ff[4].go && (pipe_ff[4].carry != '0) &&
                        (pipe_ff[4].hour != DONT_CARE);
      if (pipe_in[5].go) begin
         pipe_in[5].hour  = f_step.value;
         pipe_in[5].carry = DELTA_W'(f_step.carry);
      end
   end

   // Day.
   always_comb begin
      g_d0   = pipe_ff[5].day - 8'd1;
      g_c    = pipe_ff[5].carry[5:0];
      g_ge   = g_c >= {1'b0, pipe_ff[5].len};
      g_rc   = g_ge ? g_c - {1'b0, pipe_ff[5].len} : g_c;
      g_act  = pipe_ff[5].go && (pipe_ff[5].day != DONT_CARE) &&
               (pipe_ff[5].carry != '0) && (g_d0 != DONT_CARE);
      g_step = part_step(pipe_ff[5].sub, g_d0, {1'b0, pipe_ff[5].d0_m}, g_rc,
                         QUO_W'(g_ge), {1'b0, pipe_ff[5].len});
      pipe_in[6]    = pipe_ff[5];
      pipe_in[6].go = pipe_ff[5].go && (pipe_ff[5].day != DONT_CARE);
      if (g_act) begin
         pipe_in[6].day   = g_step.value + 8'd1;
         pipe_in[6].carry = DELTA_W'(g_step.carry);
      end
   end

   // Month.
   always_comb begin
      h_k = mod_small(pipe_ff[6].carry[8:0], MONTHS);
      if (pipe_ff[6].sub) begin
         h_t = {2'b0, pipe_ff[6].mon_t} + MONTHS - h_k;
      end else begin
         h_t = {2'b0, pipe_ff[6].mon_t} + h_k;
      end
      if (h_t >= MONTHS) begin
         h_t = h_t - MONTHS;
      end
      pipe_in[7] = pipe_ff[6];
      if (pipe_ff[6].go && pipe_ff[6].month != DONT_CARE) begin
         pipe_in[7].month = FIELD_W'(h_t) + 8'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (adv[0]) begin
            valid_ff[0] <= req_bus.valid;
         end
         for (int k = 1; k < STAGES; k++) begin
            if (adv[k]) begin
               valid_ff[k] <= valid_ff[k-1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < STAGES; k++) begin
         if (adv[k]) begin
            pipe_ff[k] <= pipe_in[k];
         end
      end
   end

   assign rsp_bus.valid      = valid_ff[STAGES-1];
   assign rsp_bus.out_second = pipe_ff[STAGES-1].second;
   assign rsp_bus.out_minute = pipe_ff[STAGES-1].minute;
   assign rsp_bus.out_hour   = pipe_ff[STAGES-1].hour;
   assign rsp_bus.out_day    = pipe_ff[STAGES-1].day;
   assign rsp_bus.out_month  = pipe_ff[STAGES-1].month;

endmodule

[rtl/ata_checker.sv]
// Port-level checks for the alarm time add/subtract block, bound to its top level.
// Depends on ata_pkg for the pipeline depth and field widths.

module ata_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_ready,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [ata_pkg::FIELD_W-1:0] rsp_second,
   input logic [ata_pkg::FIELD_W-1:0] rsp_minute,
   input logic [ata_pkg::FIELD_W-1:0] rsp_hour,
   input logic [ata_pkg::FIELD_W-1:0] rsp_day,
   input logic [ata_pkg::FIELD_W-1:0] rsp_month
);
   import ata_pkg::*;

   logic [OCC_W-1:0] occ_ff;
   logic [OCC_W-1:0] occ_in;
   logic             in_fire;
   logic             out_fire;

   assign in_fire  = req_valid && req_ready;
   assign out_fire = rsp_valid && rsp_ready;
   assign occ_in   = occ_ff + OCC_W'(in_fire) - OCC_W'(out_fire);

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= '0;
      end else begin
         occ_ff <= occ_in;
      end
   end

   // Reset empties the pipeline.
   a_reset_empty: assert property (@(posedge clock) $past(reset) && !reset |-> !rsp_valid)
      else $error("response valid right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_second) &&
      $stable(rsp_minute) && $stable(rsp_hour) && $stable(rsp_day) && $stable(rsp_month))
      else $error("stalled response transaction changed");

   // Every response transaction belongs to an accepted request transaction.
   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> occ_ff != '0)
      else $error("response without an outstanding request");

   a_empty_ready: assert property (@(posedge clock) disable iff (reset)
      occ_ff == '0 |-> req_ready)
      else $error("empty pipeline refuses a request");

   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      occ_ff == OCC_W'(STAGES) && !rsp_ready |-> !req_ready)
      else $error("full stalled pipeline accepts a request");

endmodule

bind alarm_time_add_subtract ata_checker u_ata_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_bus.valid),
   .req_ready  (req_bus.ready),
   .rsp_valid  (rsp_bus.valid),
   .rsp_ready  (rsp_bus.ready),
   .rsp_second (rsp_bus.out_second),
   .rsp_minute (rsp_bus.out_minute),
   .rsp_hour   (rsp_bus.out_hour),
   .rsp_day    (rsp_bus.out_day),
   .rsp_month  (rsp_bus.out_month)
);
